// ----- rtl/xsd_pkg.sv -----
// Shared types, codes and the xorshift16 step for the sync-word detector.
// No dependencies; used by xorshift_sync_word_detector.
`timescale 1ns / 1ps

package xsd_pkg;

    typedef logic [15:0] word_t;
    typedef logic [1:0]  status_t;
    typedef logic [3:0]  count_t;
    typedef logic [2:0]  skip_t;
    typedef logic [1:0]  reg_index_t;

    // Result status codes
    localparam status_t STATUS_IDLE     = 2'd0;
    localparam status_t STATUS_MISMATCH = 2'd1;
    localparam status_t STATUS_MATCH    = 2'd2;
    localparam status_t STATUS_LOCK     = 2'd3;

    // Configuration register indexes
    localparam reg_index_t REG_SYNC_SYMBOL    = 2'd0;
    localparam reg_index_t REG_MIN_GOOD_STEPS = 2'd1;

    localparam skip_t  SKIP_WORDS          = 3'd6;
    localparam count_t COUNT_MAX           = 4'd15;
    localparam count_t MIN_GOOD_STEPS_INIT = 4'd4;

    localparam int SHIFT_A = 7;
    localparam int SHIFT_B = 9;
    localparam int SHIFT_C = 13;

    function automatic word_t xorshift_step(input word_t v);
        word_t x;
        x = v;
        x = x ^ (x >> SHIFT_A);
        x = x ^ (x << SHIFT_B);
        x = x ^ (x >> SHIFT_C);
        return x;
    endfunction

endpackage

// ----- rtl/xorshift_sync_word_detector.sv -----
// Top level of the xorshift16 sync-word detector: input register, step/compare
// logic and result register. Depends on xsd_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: data_word with word_valid / word_stall; an item is taken at a
//   clock edge with word_valid high and word_stall low.
//   Result channel: status and good_steps with result_valid / result_stall; one
//   result item for every input item, in order.
//   Configuration: wr_en, wr_index, wr_data; index 0 is the sync symbol,
//   index 1 the minimum good-step count (low 4 bits), other indexes are dropped.
//   Write only while no item is in flight.
// Pipeline and throughput
//   The item lands in the input register at the accepting edge and moves on into
//   the result register at an edge where the result register can advance. One
//   item per cycle is sustained while result_stall stays low; the xorshift step
//   and the compare sit between those two registers.
// Reset
//   Clears the pipeline valids, the pairing, skip and good-step state, sets the
//   sync symbol to 0 and the minimum good-step count to 4.
// Stall
//   While result_stall holds a waiting result, one more item is taken into the
//   input register; then word_stall rises until the result moves on.
module xorshift_sync_word_detector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    output logic                word_stall,
    input  xsd_pkg::word_t      data_word,
    output logic                result_valid,
    input  logic                result_stall,
    output xsd_pkg::status_t    status,
    output xsd_pkg::count_t     good_steps,
    input  logic                wr_en,
    input  xsd_pkg::reg_index_t wr_index,
    input  xsd_pkg::word_t      wr_data
);

    xsd_pkg::word_t   sync_symbol_reg;
    xsd_pkg::count_t  min_good_reg;

    logic             in_valid_reg;
    xsd_pkg::word_t   in_word_reg;

    logic             have_seed_reg, have_seed_next;
    xsd_pkg::word_t   seed_reg, seed_next;
    xsd_pkg::skip_t   skip_left_reg, skip_left_next;
    xsd_pkg::count_t  step_count_reg, step_count_next;

    logic             res_valid_reg;
    xsd_pkg::status_t status_reg, status_next;
    xsd_pkg::count_t  good_reg;

    logic             res_advance;
    logic             in_accept;
    logic             item_fire;
    xsd_pkg::word_t   stepped;
    logic             enough;

    assign res_advance = !res_valid_reg || !result_stall;
    assign word_stall  = in_valid_reg && !res_advance;
    assign in_accept   = word_valid && !word_stall;

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign good_steps   = good_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_symbol_reg <= '0;
            min_good_reg    <= xsd_pkg::MIN_GOOD_STEPS_INIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                xsd_pkg::REG_SYNC_SYMBOL:    sync_symbol_reg <= wr_data;
                xsd_pkg::REG_MIN_GOOD_STEPS: min_good_reg    <= wr_data[3:0];
                default:                     ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (res_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_word_reg <= data_word;
        end
    end

    // Step, compare and count
    assign stepped = xsd_pkg::xorshift_step(seed_reg);
    assign enough  = step_count_reg >= min_good_reg;

    always_comb
    begin
        have_seed_next  = have_seed_reg;
        seed_next       = seed_reg;
        skip_left_next  = skip_left_reg;
        step_count_next = step_count_reg;
        status_next     = xsd_pkg::STATUS_IDLE;
        if (skip_left_reg != '0)
        begin
            skip_left_next = skip_left_reg - 3'd1;
        end
        else if (!have_seed_reg)
        begin
            seed_next      = in_word_reg;
            have_seed_next = 1'b1;
        end
        else
        begin
            have_seed_next = 1'b0;
            if (stepped != in_word_reg)
            begin
                step_count_next = '0;
                skip_left_next  = xsd_pkg::SKIP_WORDS;
                status_next     = xsd_pkg::STATUS_MISMATCH;
            end
            else if (enough && stepped == sync_symbol_reg)
            begin
                step_count_next = '0;
                status_next     = xsd_pkg::STATUS_LOCK;
            end
            else
            begin
                if (step_count_reg != xsd_pkg::COUNT_MAX)
                begin
                    step_count_next = step_count_reg + 4'd1;
                end
                status_next = xsd_pkg::STATUS_MATCH;
            end
        end
    end

    assign item_fire = in_valid_reg && res_advance;

    // Detector state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_seed_reg  <= 1'b0;
            skip_left_reg  <= '0;
            step_count_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else if (res_advance)
        begin
            res_valid_reg <= in_valid_reg;
            if (item_fire)
            begin
                have_seed_reg  <= have_seed_next;
                skip_left_reg  <= skip_left_next;
                step_count_reg <= step_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            seed_reg   <= seed_next;
            status_reg <= status_next;
            good_reg   <= step_count_next;
        end
    end

`ifndef SYNTHESIS
    a_lock_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == xsd_pkg::STATUS_LOCK) |-> good_steps == '0)
        else $error("lock result carries a nonzero good-step count");

    a_mismatch_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == xsd_pkg::STATUS_MISMATCH) |-> good_steps == '0)
        else $error("mismatch result carries a nonzero good-step count");

    a_skip_without_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_left_reg != '0) |-> !have_seed_reg)
        else $error("seed held while words are being skipped");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && result_valid && result_stall) |=> in_valid_reg)
        else $error("buffered item dropped while result stalled");
`endif

endmodule
